// ----- rtl/i8080bls_pkg.sv -----
// Package: opcode constants, decode entry type and the 8080 length/cycle decode table.
`timescale 1ns / 1ps
package i8080bls_pkg;

    localparam logic [7:0] OP_JMP = 8'hc3;
    localparam logic [7:0] OP_RET = 8'hc9;

    // Lengths as the table gives them; LEN_NONE marks an unlisted opcode.
    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic [1:0] len;
        logic [4:0] cycles;
    } t_decode;

    function automatic t_decode decode_opcode(input logic [7:0] op);
        t_decode d;
        d = '{len: LEN_NONE, cycles: 5'd0};
        unique case (op[7:6])
            2'b01: begin
                // MOV block: memory forms take 7, HLT slot is unlisted
                if (op == 8'h76) begin
                    d = '{len: LEN_NONE, cycles: 5'd0};
                end else if (op[2:0] == 3'd6 || op[5:3] == 3'd6) begin
                    d = '{len: LEN_ONE, cycles: 5'd7};
                end else begin
                    d = '{len: LEN_ONE, cycles: 5'd5};
                end
            end
            2'b10: begin
                // ALU block: only CMP M takes 7
                if (op[2:0] == 3'd6 && op[5:3] == 3'd7) begin
                    d = '{len: LEN_ONE, cycles: 5'd7};
                end else begin
                    d = '{len: LEN_ONE, cycles: 5'd4};
                end
            end
            2'b00: begin
                unique case (op) inside
                    8'h00, 8'h08, 8'h10, 8'h0f, 8'h1f, 8'h20, 8'h27, 8'h2f, 8'h37, 8'h3f:
                        d = '{len: LEN_ONE, cycles: 5'd4};
                    8'h01, 8'h11, 8'h21, 8'h31:
                        d = '{len: LEN_THREE, cycles: 5'd10};
                    8'h02, 8'h0a, 8'h12, 8'h1a:
                        d = '{len: LEN_ONE, cycles: 5'd7};
                    8'h03, 8'h04, 8'h05, 8'h0b, 8'h0c, 8'h0d, 8'h13, 8'h14, 8'h15,
                    8'h1b, 8'h1c, 8'h1d, 8'h23, 8'h24, 8'h25, 8'h2b, 8'h2c, 8'h2d,
                    8'h3c, 8'h3d:
                        d = '{len: LEN_ONE, cycles: 5'd5};
                    8'h06, 8'h0e, 8'h16, 8'h1e, 8'h26, 8'h2e, 8'h3e:
                        d = '{len: LEN_TWO, cycles: 5'd7};
                    8'h09, 8'h19, 8'h29, 8'h34, 8'h35:
                        d = '{len: LEN_ONE, cycles: 5'd10};
                    8'h22, 8'h2a:
                        d = '{len: LEN_THREE, cycles: 5'd16};
                    8'h32, 8'h3a:
                        d = '{len: LEN_THREE, cycles: 5'd13};
                    8'h36:
                        d = '{len: LEN_TWO, cycles: 5'd10};
                    default:
                        d = '{len: LEN_NONE, cycles: 5'd0};
                endcase
            end
            default: begin
                unique case (op) inside
                    8'hc0, 8'hc8, 8'hd0, 8'hd8, 8'he0, 8'he8, 8'hf0, 8'hf8:
                        d = '{len: LEN_ONE, cycles: 5'd5};
                    8'hc1, 8'hc9, 8'hd1, 8'he1, 8'hf1:
                        d = '{len: LEN_ONE, cycles: 5'd10};
                    8'hc2, 8'hc3, 8'hca, 8'hd2, 8'hda, 8'he2, 8'hea, 8'hf2, 8'hfa:
                        d = '{len: LEN_THREE, cycles: 5'd10};
                    8'hc4, 8'hcc, 8'hd4, 8'hdc, 8'he4, 8'hec, 8'hf4, 8'hfc:
                        d = '{len: LEN_THREE, cycles: 5'd11};
                    8'hc5, 8'hd5, 8'hd7, 8'he5, 8'hf5:
                        d = '{len: LEN_ONE, cycles: 5'd11};
                    8'hcd:
                        d = '{len: LEN_THREE, cycles: 5'd17};
                    8'hc6, 8'hce, 8'hd6, 8'hde, 8'he6, 8'hee, 8'hf6, 8'hfe:
                        d = '{len: LEN_TWO, cycles: 5'd7};
                    8'hd3, 8'hdb:
                        d = '{len: LEN_TWO, cycles: 5'd10};
                    8'he3:
                        d = '{len: LEN_ONE, cycles: 5'd18};
                    8'heb, 8'hf3, 8'hfb:
                        d = '{len: LEN_ONE, cycles: 5'd4};
                    default:
                        d = '{len: LEN_NONE, cycles: 5'd0};
                endcase
            end
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/i8080_block_length_cycle_scanner.sv -----
// Top level: 8080 basic-block scanner giving length, cycles and running total per instruction.
// Result path: the code byte that completes an instruction passes the input register, then
//   the result register, before its result shows on o_out_valid.
// Throughput: one code byte per cycle; the table decode and the 8-bit total adder sit in
//   the single stage between the two registers. A stalled result backs up into o_in_stall.
// Reset: synchronous, active low; clears valid flags and scan state, idle until block_begin.
`timescale 1ns / 1ps
module i8080_block_length_cycle_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel: one code byte per transaction
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_code_byte,
    input  logic        i_block_begin,
    input  logic [15:0] i_begin_address,
    // output channel: one decoded instruction per transaction
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_instr_address,
    output logic [7:0]  o_opcode_value,
    output logic [7:0]  o_operand_first,
    output logic [7:0]  o_operand_second,
    output logic [1:0]  o_instr_length,
    output logic [4:0]  o_instr_cycles,
    output logic [7:0]  o_cycle_total,
    output logic        o_block_end,
    output logic        o_bad_opcode
);
    import i8080bls_pkg::*;

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_begin;
    logic [15:0] r_in_address;

    // ---------------------------------------------------------------
    // Scan state
    // ---------------------------------------------------------------
    logic [15:0] r_next_address, n_next_address;
    logic [1:0]  r_bytes_pending, n_bytes_pending;
    logic [7:0]  r_held_opcode, n_held_opcode;
    logic [15:0] r_held_address, n_held_address;
    logic [7:0]  r_held_operand, n_held_operand;
    logic [4:0]  r_held_cycles, n_held_cycles;  // table cycles of the held opcode
    logic        r_held_long, n_held_long;      // held opcode is a 3-byte form
    logic [7:0]  r_running_cycles, n_running_cycles;
    logic        r_scanning, n_scanning;

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic        r_out_valid;
    logic [15:0] r_out_address;
    logic [7:0]  r_out_opcode;
    logic [7:0]  r_out_operand_first;
    logic [7:0]  r_out_operand_second;
    logic [1:0]  r_out_length;
    logic [4:0]  r_out_cycles;
    logic [7:0]  r_out_total;
    logic        r_out_end;
    logic        r_out_bad;

    // stage control
    logic        out_free;
    logic        advance;

    // decode of the byte sitting in the input register
    t_decode     dec;
    logic        active;
    logic [15:0] base_address;
    logic [1:0]  pending;
    logic [7:0]  run_base;

    // result being formed this cycle
    logic        emit;
    logic [15:0] e_address;
    logic [7:0]  e_opcode;
    logic [7:0]  e_operand_first;
    logic [7:0]  e_operand_second;
    logic [1:0]  e_length;
    logic [4:0]  e_cycles;
    logic        e_bad;
    logic        e_end;
    logic [7:0]  e_total;

    // The result register frees up when empty or when its transaction completes.
    assign out_free   = !r_out_valid || !i_out_stall;
    // Move the held byte through the decode stage only if its result has a place to go.
    assign advance    = r_in_valid && out_free;
    // Take a new byte whenever the input register is empty or drains this cycle.
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte    <= i_code_byte;
            r_in_begin   <= i_block_begin;
            r_in_address <= i_begin_address;
        end
    end

    // ---------------------------------------------------------------
    // Decode stage
    // ---------------------------------------------------------------
    assign dec = decode_opcode(r_in_byte);

    always_comb begin
        // block_begin restarts the scan: drop any partial instruction, clear the total
        active       = r_in_begin || r_scanning;
        base_address = r_in_begin ? r_in_address : r_next_address;
        pending      = r_in_begin ? 2'd0 : r_bytes_pending;
        run_base     = r_in_begin ? 8'd0 : r_running_cycles;

        n_next_address   = r_next_address;
        n_bytes_pending  = r_bytes_pending;
        n_held_opcode    = r_held_opcode;
        n_held_address   = r_held_address;
        n_held_operand   = r_held_operand;
        n_held_cycles    = r_held_cycles;
        n_held_long      = r_held_long;
        n_running_cycles = r_running_cycles;
        n_scanning       = r_scanning;

        emit             = 1'b0;
        e_address        = base_address;
        e_opcode         = r_in_byte;
        e_operand_first  = 8'd0;
        e_operand_second = 8'd0;
        e_length         = LEN_ONE;
        e_cycles         = 5'd0;
        e_bad            = 1'b0;

        if (advance && r_in_begin) begin
            n_scanning       = 1'b1;
            n_bytes_pending  = 2'd0;
            n_running_cycles = 8'd0;
            n_next_address   = r_in_address;
        end

        if (advance && active) begin
            n_next_address = base_address + 16'd1;
            if (pending == 2'd0) begin
                if (dec.len == LEN_NONE) begin
                    emit  = 1'b1;
                    e_bad = 1'b1;
                end else if (dec.len == LEN_ONE) begin
                    emit     = 1'b1;
                    e_cycles = dec.cycles;
                end else begin
                    // hold the opcode and wait for its operand bytes
                    n_held_opcode   = r_in_byte;
                    n_held_address  = base_address;
                    n_held_operand  = 8'd0;
                    n_held_cycles   = dec.cycles;
                    n_held_long     = (dec.len == LEN_THREE);
                    n_bytes_pending = dec.len - 2'd1;
                end
            end else if (pending == 2'd2) begin
                n_held_operand  = r_in_byte;
                n_bytes_pending = 2'd1;
            end else begin
                // last operand byte: complete the held instruction
                emit      = 1'b1;
                e_address = r_held_address;
                e_opcode  = r_held_opcode;
                e_cycles  = r_held_cycles;
                if (r_held_long) begin
                    e_operand_first  = r_held_operand;
                    e_operand_second = r_in_byte;
                    e_length         = LEN_THREE;
                end else begin
                    e_operand_first = r_in_byte;
                    e_length        = LEN_TWO;
                end
            end
        end

        e_end   = e_bad || e_opcode == OP_JMP || e_opcode == OP_RET;
        e_total = run_base + {3'd0, e_cycles};

        if (emit) begin
            n_running_cycles = e_total;
            n_bytes_pending  = 2'd0;
            if (e_end) begin
                n_scanning = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_address   <= 16'd0;
            r_bytes_pending  <= 2'd0;
            r_held_opcode    <= 8'd0;
            r_held_address   <= 16'd0;
            r_held_operand   <= 8'd0;
            r_held_cycles    <= 5'd0;
            r_held_long      <= 1'b0;
            r_running_cycles <= 8'd0;
            r_scanning       <= 1'b0;
        end else begin
            r_next_address   <= n_next_address;
            r_bytes_pending  <= n_bytes_pending;
            r_held_opcode    <= n_held_opcode;
            r_held_address   <= n_held_address;
            r_held_operand   <= n_held_operand;
            r_held_cycles    <= n_held_cycles;
            r_held_long      <= n_held_long;
            r_running_cycles <= n_running_cycles;
            r_scanning       <= n_scanning;
        end
    end

    // ---------------------------------------------------------------
    // Result register: load on emit, drop once the transaction completes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_address        <= e_address;
            r_out_opcode         <= e_opcode;
            r_out_operand_first  <= e_operand_first;
            r_out_operand_second <= e_operand_second;
            r_out_length         <= e_length;
            r_out_cycles         <= e_cycles;
            r_out_total          <= e_total;
            r_out_end            <= e_end;
            r_out_bad            <= e_bad;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_instr_address  = r_out_address;
    assign o_opcode_value   = r_out_opcode;
    assign o_operand_first  = r_out_operand_first;
    assign o_operand_second = r_out_operand_second;
    assign o_instr_length   = r_out_length;
    assign o_instr_cycles   = r_out_cycles;
    assign o_cycle_total    = r_out_total;
    assign o_block_end      = r_out_end;
    assign o_bad_opcode     = r_out_bad;

endmodule

// ----- rtl/i8080bls_checker.sv -----
// Checker: port-level properties of the block scanner, bound to the top level.
`timescale 1ns / 1ps
module i8080bls_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_instr_address,
    input logic [7:0]  o_opcode_value,
    input logic [7:0]  o_operand_first,
    input logic [7:0]  o_operand_second,
    input logic [1:0]  o_instr_length,
    input logic [4:0]  o_instr_cycles,
    input logic [7:0]  o_cycle_total,
    input logic        o_block_end,
    input logic        o_bad_opcode
);
    import i8080bls_pkg::*;

    // Hold a stalled result unchanged until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_instr_address) && $stable(o_opcode_value)
            && $stable(o_cycle_total) && $stable(o_block_end))
        else $error("stalled result changed");

    // An unlisted opcode ends the block as a one-byte, zero-cycle result.
    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_opcode |->
            o_block_end && o_instr_cycles == 5'd0 && o_instr_length == LEN_ONE
            && o_operand_first == 8'd0 && o_operand_second == 8'd0)
        else $error("bad opcode result malformed");

    // Short forms carry zeros in their unused operand fields.
    a_short_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_instr_length != LEN_THREE |->
            o_operand_second == 8'd0
            && (o_instr_length != LEN_ONE || o_operand_first == 8'd0))
        else $error("operand of short instruction not zero");

    // JMP and RET always end the block; nothing else does unless it is unlisted.
    a_end_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_block_end == (o_bad_opcode || o_opcode_value == OP_JMP
                            || o_opcode_value == OP_RET))
        else $error("block end flag wrong");

    // No empty length code ever leaves the block.
    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_instr_length != LEN_NONE && o_instr_cycles <= 5'd18)
        else $error("length or cycles out of range");

endmodule

bind i8080_block_length_cycle_scanner i8080bls_checker u_i8080bls_checker (.*);

// ----- bench/i8080_block_length_cycle_scanner_tb.sv -----
// Testbench for the 8080 basic-block scanner: directed table, opcode sweep, random blocks.
`timescale 1ns / 1ps
module i8080_block_length_cycle_scanner_tb;
    import i8080bls_pkg::*;

    // Size of the random part in code bytes (noise bytes do not count).
    localparam int ITEM_TARGET = 1250;
    // Hard stop for a hung run, in ns.
    localparam int RUN_LIMIT_NS = 1_000_000;

    // Receiver stall patterns.
    localparam int STALL_OFF      = 0;
    localparam int STALL_PERIODIC = 1;
    localparam int STALL_RANDOM   = 2;
    localparam int STALL_HEAVY    = 3;
    localparam int STALL_HOLD     = 4;
    // Phase of the receiver at which the long hold-off happens.
    localparam int HOLD_PHASE     = 6;
    localparam int HOLD_CYCLES    = 150;

    // One decoded instruction as it leaves the block.
    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  opcode;
        logic [7:0]  opnd1;
        logic [7:0]  opnd2;
        logic [1:0]  len;
        logic [4:0]  cycles;
        logic [7:0]  total;
        logic        blk_end;
        logic        bad;
    } t_instr;

    // One code byte to send; typed rows carry the result they must produce.
    typedef struct packed {
        logic [7:0]  code;
        logic        blk_begin;
        logic [15:0] begin_addr;
        logic        typed;
        t_instr      want;
    } t_code_item;

    localparam t_instr NO_WANT = '0;

    // Decode table entries: length in [6:5] (0 = unlisted), cycles in [4:0].
    // Opcodes 0x00..0x3f, one 8-opcode row per word, lowest opcode leftmost.
    localparam logic [511:0] LOW_ROWS = {
        64'h246a272525254700, 64'h242a272525254724,
        64'h246a272525254700, 64'h002a272525254724,
        64'h246a702525254724, 64'h002a702525254724,
        64'h006a6d002a2a4a24, 64'h00006d0025254724
    };
    // Opcodes 0xc0..0xff.
    localparam logic [511:0] HIGH_ROWS = {
        64'h252a6a6a6b2b4700, 64'h252a6a006b714700,
        64'h252a6a4a6b2b472b, 64'h25006a4a6b004700,
        64'h252a6a326b2b4700, 64'h25006a246b004700,
        64'h252a6a246b2b4700, 64'h25006a246b004700
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_code_byte;
    logic        i_block_begin;
    logic [15:0] i_begin_address;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_instr_address;
    logic [7:0]  o_opcode_value;
    logic [7:0]  o_operand_first;
    logic [7:0]  o_operand_second;
    logic [1:0]  o_instr_length;
    logic [4:0]  o_instr_cycles;
    logic [7:0]  o_cycle_total;
    logic        o_block_end;
    logic        o_bad_opcode;

    i8080_block_length_cycle_scanner DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_code_byte      (i_code_byte),
        .i_block_begin    (i_block_begin),
        .i_begin_address  (i_begin_address),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_instr_address  (o_instr_address),
        .o_opcode_value   (o_opcode_value),
        .o_operand_first  (o_operand_first),
        .o_operand_second (o_operand_second),
        .o_instr_length   (o_instr_length),
        .o_instr_cycles   (o_instr_cycles),
        .o_cycle_total    (o_cycle_total),
        .o_block_end      (o_block_end),
        .o_bad_opcode     (o_bad_opcode)
    );

    // Decode table and scan state of the predictor.
    logic [6:0]  op_table [256];
    logic [15:0] scan_next_addr;
    logic [1:0]  scan_pending;
    logic [7:0]  scan_held_op;
    logic [15:0] scan_held_addr;
    logic [7:0]  scan_held_opnd;
    logic [7:0]  scan_cycle_sum;
    logic        scan_active;

    t_code_item  send_q[$];
    t_code_item  cur_item;
    t_instr      expected_instrs[$];
    bit          feed_done;
    int          fail_count;
    int          n_bytes;
    int          n_results;
    int          n_blocks;
    int          n_bad;
    int          n_wraps;

    initial begin : clk_gen
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Fill the decode table: the two outer quarters come from the row words,
    // the MOV and ALU quarters follow their regular pattern.
    function automatic void fill_decode_table();
        for (int i = 0; i < 64; i++) begin
            op_table[i]       = LOW_ROWS[(63 - i) * 8 +: 7];
            op_table[192 + i] = HIGH_ROWS[(63 - i) * 8 +: 7];
            // MOV block: memory source or destination takes 7; the HLT slot is unlisted
            if (i[5:3] == 3'd6)
                op_table[64 + i] = (i[2:0] == 3'd6) ? {LEN_NONE, 5'd0} : {LEN_ONE, 5'd7};
            else
                op_table[64 + i] = (i[2:0] == 3'd6) ? {LEN_ONE, 5'd7} : {LEN_ONE, 5'd5};
            // ALU block: only CMP M takes 7
            op_table[128 + i] = (i[5:0] == 6'h3e) ? {LEN_ONE, 5'd7} : {LEN_ONE, 5'd4};
        end
    endfunction

    // Bytes an opcode occupies; an unlisted opcode stands alone.
    function automatic int byte_len(input logic [7:0] op);
        return (op_table[op][6:5] == LEN_NONE) ? 1 : int'(op_table[op][6:5]);
    endfunction

    // Close an instruction: add its cycles to the block total, end the block on
    // JMP, RET or an unlisted opcode.
    function automatic t_instr close_instr(input logic [15:0] at, input logic [7:0] op,
                                           input logic [7:0] b1, input logic [7:0] b2,
                                           input logic [1:0] len, input logic bad);
        t_instr r;
        r.addr    = at;
        r.opcode  = op;
        r.opnd1   = b1;
        r.opnd2   = b2;
        r.len     = len;
        r.cycles  = bad ? 5'd0 : op_table[op][4:0];
        r.total   = scan_cycle_sum + 8'(r.cycles);
        r.blk_end = bad || op == OP_JMP || op == OP_RET;
        r.bad     = bad;
        if (r.total < scan_cycle_sum)
            n_wraps++;
        if (bad)
            n_bad++;
        scan_cycle_sum = r.total;
        if (r.blk_end)
            scan_active = 1'b0;
        scan_pending = 2'd0;
        return r;
    endfunction

    // Advance the scan by one accepted code byte; return 1 when it completes an
    // instruction.
    function automatic bit decode_code_byte(input logic [7:0] b, input logic bb,
                                            input logic [15:0] ba, output t_instr r);
        logic [15:0] at;
        logic [1:0]  len;
        r = '0;
        if (bb) begin
            scan_next_addr = ba;
            scan_cycle_sum = 8'd0;
            scan_pending   = 2'd0;
            scan_active    = 1'b1;
            n_blocks++;
        end
        if (!scan_active)
            return 1'b0;
        at = scan_next_addr;
        scan_next_addr = scan_next_addr + 16'd1;
        if (scan_pending == 2'd0) begin
            len = op_table[b][6:5];
            if (len == LEN_NONE) begin
                r = close_instr(at, b, 8'h00, 8'h00, LEN_ONE, 1'b1);
                return 1'b1;
            end
            if (len == LEN_ONE) begin
                r = close_instr(at, b, 8'h00, 8'h00, LEN_ONE, 1'b0);
                return 1'b1;
            end
            scan_held_op   = b;
            scan_held_addr = at;
            scan_held_opnd = 8'h00;
            scan_pending   = len - 2'd1;
            return 1'b0;
        end
        if (scan_pending == 2'd2) begin
            scan_held_opnd = b;
            scan_pending   = 2'd1;
            return 1'b0;
        end
        if (op_table[scan_held_op][6:5] == LEN_THREE)
            r = close_instr(scan_held_addr, scan_held_op, scan_held_opnd, b, LEN_THREE, 1'b0);
        else
            r = close_instr(scan_held_addr, scan_held_op, b, 8'h00, LEN_TWO, 1'b0);
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_opcode(input bit listed);
        logic [7:0] op;
        bit         ok;
        ok = 1'b0;
        op = 8'h00;
        while (!ok) begin
            op = 8'($urandom_range(0, 255));
            if (listed)
                ok = op_table[op][6:5] != LEN_NONE && op != OP_JMP && op != OP_RET;
            else
                ok = op_table[op][6:5] == LEN_NONE;
        end
        return op;
    endfunction

    // Queue the first n bytes of an instruction: opcode, then random operands.
    task automatic push_bytes(input logic [7:0] op, input int n, inout bit first);
        t_code_item it;
        for (int j = 0; j < n; j++) begin
            it            = '0;
            it.code       = (j == 0) ? op : 8'($urandom_range(0, 255));
            it.blk_begin  = (j == 0) ? first : 1'b0;
            it.begin_addr = 16'($urandom_range(0, 65535));
            send_q.push_back(it);
            first = 1'b0;
        end
    endtask

    // Random part: every opcode once as its own block, then random blocks.
    task automatic plan_blocks();
        int         planned;
        int         body;
        int         pick;
        int         n;
        bit         first;
        bit         idle;
        logic [7:0] op;
        t_code_item it;
        planned = 0;
        for (int op_i = 0; op_i < 256; op_i++) begin
            first = 1'b1;
            push_bytes(op_i[7:0], byte_len(op_i[7:0]), first);
            planned += byte_len(op_i[7:0]);
        end
        // the sweep ends on 0xff, which is unlisted, so the scanner is idle
        idle = 1'b1;
        while (planned < ITEM_TARGET) begin
            // drop a few stray bytes on the idle scanner
            if (idle) begin
                repeat ($urandom_range(0, 2)) begin
                    it            = '0;
                    it.code       = 8'($urandom_range(0, 255));
                    it.begin_addr = 16'($urandom_range(0, 65535));
                    send_q.push_back(it);
                end
            end
            first = 1'b1;
            // mostly short blocks; some long enough to wrap the cycle total
            body = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 12);
            repeat (body) begin
                op = pick_opcode(1'b1);
                push_bytes(op, byte_len(op), first);
                planned += byte_len(op);
            end
            pick = $urandom_range(0, 99);
            idle = 1'b1;
            if (pick < 92) begin
                if (pick < 42)
                    op = OP_JMP;
                else if (pick < 84)
                    op = OP_RET;
                else
                    op = pick_opcode(1'b0);
                push_bytes(op, byte_len(op), first);
                planned += byte_len(op);
            end else begin
                // leave the block open, maybe mid-instruction; the next start drops it
                op = pick_opcode(1'b1);
                n  = $urandom_range(0, byte_len(op) - 1);
                push_bytes(op, n, first);
                planned += n;
                idle = 1'b0;
            end
        end
    endtask

    // Sender: directed table first, then the random part, in bursts with gaps.
    initial begin : feed
        t_code_item directed [19];
        t_code_item it;
        int         burst_left;
        int         gap;
        i_in_valid      = 1'b0;
        i_code_byte     = 8'h00;
        i_block_begin   = 1'b0;
        i_begin_address = 16'h0000;
        cur_item        = '0;
        feed_done       = 1'b0;
        fill_decode_table();

        //              code   begin  begin addr  typed  addr      op     opnd1  opnd2  len   cyc
        //              total  end   bad
        // byte while idle: ignored
        directed[0]  = {8'h00, 1'b0, 16'h0000, 1'b0, NO_WANT};
        // start at the top address; NOP
        directed[1]  = {8'h00, 1'b1, 16'hffff, 1'b1, 16'hffff, 8'h00, 8'h00, 8'h00, 2'd1, 5'd4,
                        8'd4, 1'b0, 1'b0};
        // CALL across the address wrap, operands at the extremes
        directed[2]  = {8'hcd, 1'b0, 16'h0000, 1'b0, NO_WANT};
        directed[3]  = {8'hff, 1'b0, 16'hffff, 1'b0, NO_WANT};
        directed[4]  = {8'h00, 1'b0, 16'h0000, 1'b1, 16'h0000, 8'hcd, 8'hff, 8'h00, 2'd3, 5'd17,
                        8'd21, 1'b0, 1'b0};
        // XTHL, the largest cycle count
        directed[5]  = {8'he3, 1'b0, 16'h0000, 1'b1, 16'h0003, 8'he3, 8'h00, 8'h00, 2'd1, 5'd18,
                        8'd39, 1'b0, 1'b0};
        // MVI B, checked by the predictor
        directed[6]  = {8'h06, 1'b0, 16'h0000, 1'b0, NO_WANT};
        directed[7]  = {8'ha5, 1'b0, 16'h5a5a, 1'b0, NO_WANT};
        // LHLD cut off by a new block start
        directed[8]  = {8'h2a, 1'b0, 16'h0000, 1'b0, NO_WANT};
        directed[9]  = {8'h7e, 1'b1, 16'h8000, 1'b1, 16'h8000, 8'h7e, 8'h00, 8'h00, 2'd1, 5'd7,
                        8'd7, 1'b0, 1'b0};
        // HLT slot is unlisted: error result, block ends
        directed[10] = {8'h76, 1'b0, 16'h0000, 1'b1, 16'h8001, 8'h76, 8'h00, 8'h00, 2'd1, 5'd0,
                        8'd7, 1'b1, 1'b1};
        directed[11] = {8'h12, 1'b0, 16'hffff, 1'b0, NO_WANT};
        // RET alone
        directed[12] = {8'hc9, 1'b1, 16'h1234, 1'b1, 16'h1234, 8'hc9, 8'h00, 8'h00, 2'd1, 5'd10,
                        8'd10, 1'b1, 1'b0};
        // JMP alone
        directed[13] = {8'hc3, 1'b1, 16'h0100, 1'b0, NO_WANT};
        directed[14] = {8'h00, 1'b0, 16'h0000, 1'b0, NO_WANT};
        directed[15] = {8'hff, 1'b0, 16'h0000, 1'b1, 16'h0100, 8'hc3, 8'h00, 8'hff, 2'd3, 5'd10,
                        8'd10, 1'b1, 1'b0};
        // OUT just below the top address, then an unlisted opcode at the top
        directed[16] = {8'hd3, 1'b1, 16'hfffd, 1'b0, NO_WANT};
        directed[17] = {8'h5a, 1'b0, 16'h0000, 1'b0, NO_WANT};
        directed[18] = {8'hff, 1'b0, 16'h0000, 1'b1, 16'hffff, 8'hff, 8'h00, 8'h00, 2'd1, 5'd0,
                        8'd10, 1'b1, 1'b1};
        foreach (directed[i])
            send_q.push_back(directed[i]);
        plan_blocks();

        @(posedge i_rst_n);
        burst_left = 0;
        while (send_q.size() != 0) begin
            it = send_q.pop_front();
            if (burst_left == 0) begin
                // idle between bursts; sometimes go straight on
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 30);
                repeat (gap) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                end
            end
            @(negedge i_clk);
            i_in_valid      <= 1'b1;
            i_code_byte     <= it.code;
            i_block_begin   <= it.blk_begin;
            i_begin_address <= it.begin_addr;
            cur_item        <= it;
            burst_left--;
            // hold the transaction until the block takes it
            do @(posedge i_clk); while (o_in_stall);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        feed_done = 1'b1;
    end

    // Receiver: stall on changing patterns, with one long hold-off that backs
    // the block up into its input.
    initial begin : drain
        int phase;
        int mode;
        int span;
        int k;
        i_out_stall = 1'b0;
        phase = 0;
        @(posedge i_rst_n);
        forever begin
            phase++;
            mode = $urandom_range(STALL_OFF, STALL_HEAVY);
            span = $urandom_range(10, 120);
            k    = $urandom_range(2, 5);
            if (phase == HOLD_PHASE) begin
                mode = STALL_HOLD;
                span = HOLD_CYCLES;
            end
            for (int c = 0; c < span; c++) begin
                @(negedge i_clk);
                case (mode)
                    STALL_OFF:      i_out_stall <= 1'b0;
                    STALL_PERIODIC: i_out_stall <= (c % k) == 0;
                    STALL_RANDOM:   i_out_stall <= 1'($urandom_range(0, 1));
                    STALL_HEAVY:    i_out_stall <= (c % k) != 0;
                    default:        i_out_stall <= 1'b1;
                endcase
            end
        end
    end

    // Input monitor: run the predictor on every accepted transaction.
    always @(posedge i_clk) begin : in_mon
        t_instr r;
        bit     done;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            done = decode_code_byte(i_code_byte, i_block_begin, i_begin_address, r);
            n_bytes++;
            if (cur_item.typed)
                expected_instrs.push_back(cur_item.want);
            else if (done)
                expected_instrs.push_back(r);
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Output monitor: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : out_mon
        t_instr want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_instrs.size() == 0) begin
                $error("unexpected result: address 0x%0h opcode 0x%0h",
                       o_instr_address, o_opcode_value);
                fail_count++;
            end else begin
                want = expected_instrs.pop_front();
                n_results++;
                check_field("instr_address", want.addr, o_instr_address);
                check_field("opcode_value", want.opcode, o_opcode_value);
                check_field("operand_first", want.opnd1, o_operand_first);
                check_field("operand_second", want.opnd2, o_operand_second);
                check_field("instr_length", want.len, o_instr_length);
                check_field("instr_cycles", want.cycles, o_instr_cycles);
                check_field("cycle_total", want.total, o_cycle_total);
                check_field("block_end", want.blk_end, o_block_end);
                check_field("bad_opcode", want.bad, o_bad_opcode);
            end
        end
    end

    // Reset once, then wait for the stimulus and the last result.
    initial begin : run_ctrl
        fail_count     = 0;
        n_bytes        = 0;
        n_results      = 0;
        n_blocks       = 0;
        n_bad          = 0;
        n_wraps        = 0;
        scan_next_addr = 16'h0000;
        scan_pending   = 2'd0;
        scan_held_op   = 8'h00;
        scan_held_addr = 16'h0000;
        scan_held_opnd = 8'h00;
        scan_cycle_sum = 8'h00;
        scan_active    = 1'b0;
        i_rst_n        = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (feed_done);
        while (expected_instrs.size() != 0) @(posedge i_clk);
        // allow for the two-register pipeline and a margin
        repeat (10) @(posedge i_clk);
        $display("Scanned %0d code bytes in %0d blocks; checked %0d instructions,",
                 n_bytes, n_blocks, n_results);
        $display("including %0d unlisted opcodes and %0d cycle-total wraps.", n_bad, n_wraps);
        if (fail_count == 0)
            $display("i8080_block_length_cycle_scanner test passed");
        else
            $display("i8080_block_length_cycle_scanner test failed");
        $finish;
    end

    initial begin : watchdog
        #RUN_LIMIT_NS;
        $display("Timeout with %0d results outstanding", expected_instrs.size());
        $display("i8080_block_length_cycle_scanner test failed");
        $finish;
    end

endmodule
